@@ design/mmep_pkg.sv @@
package mmep_pkg;

	// Field widths of the channels.
	localparam int unsigned RMS_W   = 16;
	localparam int unsigned POWER_W = 28;
	localparam int unsigned FREQ_W  = 17;
	localparam int unsigned MODE_W  = 4;
	localparam int unsigned HWH_W   = 48;
	localparam int unsigned PULSE_W = 2;
	localparam int unsigned THR_W   = 16;

	// Configuration registers.
	localparam int unsigned CFG_COUNT  = 2;
	localparam int unsigned CFG_ADDR_W = $clog2(CFG_COUNT);
	localparam logic [CFG_ADDR_W-1:0] CFG_START_VOLT = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] CFG_START_CURR = CFG_ADDR_W'(1);

	// Meter mode codes as seen on the result channel.
	localparam logic [MODE_W-1:0] MODE_START        = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_WAIT_CURRENT = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_WAIT_LOCK    = MODE_W'(2);
	localparam logic [MODE_W-1:0] MODE_RUN_A        = MODE_W'(3);
	localparam logic [MODE_W-1:0] MODE_RUN_B        = MODE_W'(4);
	localparam logic [MODE_W-1:0] MODE_RUN_C        = MODE_W'(5);
	localparam logic [MODE_W-1:0] MODE_RUN_THREE    = MODE_W'(6);
	localparam logic [MODE_W-1:0] MODE_WARNING      = MODE_W'(7);
	localparam logic [MODE_W-1:0] MODE_ERROR        = MODE_W'(8);

	// Line frequency limits in 1/1024 Hz.
	localparam logic [FREQ_W-1:0] FREQ_MIN = FREQ_W'(40960);
	localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(71680);

	// Residual energy, in 1/256 Ws. One hWh is 36000 Ws, or 9216000 of these units.
	// After reduction the residual stays below one unit; three phase additions of at
	// most 2^37/40960 each keep it well inside 26 signed bits.
	localparam int unsigned RES_W = 26;
	localparam logic signed [RES_W-1:0] HWH_UNIT = RES_W'(9216000);

	// Per-hWh step count: at most two whole units move in one item.
	localparam int unsigned STEP_W = 3;

	// Serial divider: |power| * 1024 / frequency fits in 22 bits.
	localparam int unsigned QUO_W = 22;
	localparam int unsigned REM_W = FREQ_W;

	// Lock counter.
	localparam int unsigned LOCK_W = 2;
	localparam logic [LOCK_W-1:0] LOCK_MAX = LOCK_W'(3);

	localparam int unsigned PHASES = 3;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOAD = 6'b000010,
		S_DIV  = 6'b000100,
		S_ACC  = 6'b001000,
		S_RED  = 6'b010000,
		S_FIN  = 6'b100000
	} seq_state_t;

endpackage

@@ design/mmep_cfg_if.sv @@
interface mmep_cfg_if
	import mmep_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [THR_W-1:0]      data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ design/mmep_in_if.sv @@
interface mmep_in_if
	import mmep_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic [RMS_W-1:0]          rms_volt_a;
	logic [RMS_W-1:0]          rms_volt_b;
	logic [RMS_W-1:0]          rms_volt_c;
	logic [RMS_W-1:0]          rms_curr_a;
	logic [RMS_W-1:0]          rms_curr_b;
	logic [RMS_W-1:0]          rms_curr_c;
	logic signed [POWER_W-1:0] power_a;
	logic signed [POWER_W-1:0] power_b;
	logic signed [POWER_W-1:0] power_c;
	logic                      pll_locked;
	logic [FREQ_W-1:0]         line_frequency;

	modport source (
		output valid, input ready,
		output rms_volt_a, output rms_volt_b, output rms_volt_c,
		output rms_curr_a, output rms_curr_b, output rms_curr_c,
		output power_a, output power_b, output power_c,
		output pll_locked, output line_frequency
	);
	modport sink (
		input valid, output ready,
		input rms_volt_a, input rms_volt_b, input rms_volt_c,
		input rms_curr_a, input rms_curr_b, input rms_curr_c,
		input power_a, input power_b, input power_c,
		input pll_locked, input line_frequency
	);
endinterface

@@ design/mmep_out_if.sv @@
interface mmep_out_if
	import mmep_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       meter_mode;
	logic signed [HWH_W-1:0] energy_total;
	logic [PULSE_W-1:0]      pulse_count;

	modport source (
		output valid, input ready,
		output meter_mode, output energy_total, output pulse_count
	);
	modport sink (
		input valid, output ready,
		input meter_mode, input energy_total, input pulse_count
	);
endinterface

@@ design/meter_mode_and_energy_pulses_top.sv @@
// Channel   Direction  Handshake     Payload
// cfg       in         valid/ready   addr (register index), data (threshold)
// item      in         valid/ready   RMS volts/currents, powers, PLL lock, frequency
// result    out        valid/ready   meter_mode, energy_total, pulse_count
//
// An item that does not run the meter goes straight to the final step, which registers
// its result; the next item is taken only once the block is back at idle.
// A running item takes, per counted phase in the shared serial divider, one load step,
// 22 quotient-bit steps and one accumulate step; then one load step that finds no phase
// left, two hWh reduction steps and the final step.
// arst_n clears the mode machine, the lock counter, the residual and the hWh total.
// The next item is accepted while a finished result still waits in the output
// register; a stall on the result channel only holds the block at its final step.
module meter_mode_and_energy_pulses_top
	import mmep_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mmep_cfg_if.sink     cfg,
	mmep_in_if.sink      item,
	mmep_out_if.source   result
);

	// Configuration registers. Writes are always taken.
	logic [THR_W-1:0] volt_thr_q;
	logic [THR_W-1:0] curr_thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_thr_q <= '0;
			curr_thr_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.addr == CFG_START_VOLT) begin
				volt_thr_q <= cfg.data;
			end
			if (cfg.addr == CFG_START_CURR) begin
				curr_thr_q <= cfg.data;
			end
		end
	end

	// Sequencer and architectural state.
	seq_state_t              state_q;
	logic [MODE_W-1:0]       mode_q;
	logic [LOCK_W-1:0]       lock_q;
	logic signed [RES_W-1:0] res_q;
	logic [HWH_W-1:0]        hwh_q;

	// Per-item working registers.
	logic signed [POWER_W-1:0] pow_q [PHASES];
	logic [FREQ_W-1:0]         freq_q;
	logic [PHASES-1:0]         use_q;
	logic [1:0]                sel_q;
	logic [REM_W-1:0]          rem_q;
	logic [QUO_W-1:0]          dvd_q;
	logic [QUO_W-1:0]          quo_q;
	logic                      neg_q;
	logic [$clog2(QUO_W)-1:0]  step_q;
	logic                      red_q;
	logic signed [STEP_W-1:0]  n_q;

	// Output register.
	logic                    out_valid_q;
	logic [MODE_W-1:0]       out_mode_q;
	logic [HWH_W-1:0]        out_hwh_q;
	logic [PULSE_W-1:0]      out_pulse_q;

	localparam logic [$clog2(QUO_W)-1:0] LAST_STEP = ($clog2(QUO_W))'(QUO_W - 1);

	logic accept;
	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	// Phase qualification and mode transition for the item being offered.
	logic [PHASES-1:0]    on;
	logic [1:0]           on_cnt;
	logic [MODE_W-1:0]    mode_pre;
	logic [MODE_W-1:0]    mode_nxt;
	logic [LOCK_W-1:0]    lock_nxt;
	logic [PHASES-1:0]    use_nxt;
	logic [FREQ_W-1:0]    freq_clamp;

	always_comb begin
		on[0] = (item.rms_volt_a > volt_thr_q) && (item.rms_curr_a > curr_thr_q);
		on[1] = (item.rms_volt_b > volt_thr_q) && (item.rms_curr_b > curr_thr_q);
		on[2] = (item.rms_volt_c > volt_thr_q) && (item.rms_curr_c > curr_thr_q);
		on_cnt = 2'({1'b0, on[0]} + {1'b0, on[1]} + {1'b0, on[2]});

		// Lost lock and the phase count decide before the mode itself acts.
		mode_pre = item.pll_locked ? mode_q : MODE_WAIT_LOCK;
		if (on_cnt == 2'd2) begin
			mode_pre = MODE_ERROR;
		end else if (on_cnt == 2'd0) begin
			mode_pre = MODE_WAIT_CURRENT;
		end else if (mode_pre == MODE_WAIT_CURRENT) begin
			mode_pre = MODE_WAIT_LOCK;
		end

		mode_nxt = mode_pre;
		lock_nxt = lock_q;
		use_nxt  = '0;
		unique case (mode_pre)
			MODE_START: begin
				mode_nxt = MODE_WAIT_CURRENT;
			end
			MODE_WAIT_LOCK: begin
				// After more than three locked items the meter starts running.
				if (item.pll_locked) begin
					if (lock_q == LOCK_MAX) begin
						lock_nxt = '0;
						if (&on) begin
							mode_nxt = MODE_RUN_THREE;
						end else if (on[0]) begin
							mode_nxt = MODE_RUN_A;
						end else if (on[1]) begin
							mode_nxt = MODE_RUN_B;
						end else begin
							mode_nxt = MODE_RUN_C;
						end
					end else begin
						lock_nxt = lock_q + LOCK_W'(1);
					end
				end
			end
			MODE_RUN_A:     use_nxt = 3'b001;
			MODE_RUN_B:     use_nxt = 3'b010;
			MODE_RUN_C:     use_nxt = 3'b100;
			MODE_RUN_THREE: use_nxt = 3'b111;
			default:        ;
		endcase

		if (item.line_frequency < FREQ_MIN) begin
			freq_clamp = FREQ_MIN;
		end else if (item.line_frequency > FREQ_MAX) begin
			freq_clamp = FREQ_MAX;
		end else begin
			freq_clamp = item.line_frequency;
		end
	end

	// Lowest phase still to be counted.
	logic [1:0] sel_nxt;
	always_comb begin
		priority if (use_q[0]) begin
			sel_nxt = 2'd0;
		end else if (use_q[1]) begin
			sel_nxt = 2'd1;
		end else begin
			sel_nxt = 2'd2;
		end
	end

	// Divider load: the dividend is |power| shifted up by ten bits. Its top 16 bits
	// are already below the smallest divisor, so only 22 quotient bits remain.
	logic signed [POWER_W-1:0] pow_sel;
	logic [POWER_W-1:0]        pow_mag;
	assign pow_sel = pow_q[sel_nxt];
	assign pow_mag = pow_sel[POWER_W-1] ? POWER_W'(-pow_sel) : POWER_W'(pow_sel);

	// Shared restoring divide step: one quotient bit per cycle.
	logic [REM_W:0]   trial;
	logic [REM_W+1:0] diff;
	logic             qbit;
	assign trial = {rem_q, dvd_q[QUO_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, freq_q};
	assign qbit  = ~diff[REM_W+1];

	// Signed quotient into the residual.
	logic signed [RES_W-1:0] quo_s;
	assign quo_s = neg_q ? -$signed({{(RES_W-QUO_W){1'b0}}, quo_q})
	                     : $signed({{(RES_W-QUO_W){1'b0}}, quo_q});

	// Result of this item.
	logic [HWH_W-1:0]   hwh_nxt;
	logic [PULSE_W-1:0] pulse_nxt;
	logic               out_free;
	logic               load_out;
	assign hwh_nxt   = hwh_q + {{(HWH_W-STEP_W){n_q[STEP_W-1]}}, n_q};
	assign pulse_nxt = n_q[STEP_W-1] ? PULSE_W'(-n_q) : PULSE_W'(n_q);
	assign out_free  = !out_valid_q || result.ready;
	assign load_out  = (state_q == S_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_START;
			lock_q      <= '0;
			res_q       <= '0;
			hwh_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one taken in the same cycle.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q  <= mode_nxt;
						lock_q  <= lock_nxt;
						state_q <= (use_nxt != '0) ? S_LOAD : S_FIN;
					end
				end
				S_LOAD: begin
					state_q <= (use_q != '0) ? S_DIV : S_RED;
				end
				S_DIV: begin
					if (step_q == LAST_STEP) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					res_q   <= res_q + quo_s;
					state_q <= S_LOAD;
				end
				S_RED: begin
					// Move whole hWh units out, truncating toward zero.
					if (res_q >= HWH_UNIT) begin
						res_q <= res_q - HWH_UNIT;
					end else if (res_q <= -HWH_UNIT) begin
						res_q <= res_q + HWH_UNIT;
					end
					if (red_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						hwh_q   <= hwh_nxt;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				pow_q[0] <= item.power_a;
				pow_q[1] <= item.power_b;
				pow_q[2] <= item.power_c;
				freq_q   <= freq_clamp;
				use_q    <= use_nxt;
				n_q      <= '0;
				red_q    <= 1'b0;
			end
			S_LOAD: begin
				sel_q  <= sel_nxt;
				neg_q  <= pow_sel[POWER_W-1];
				rem_q  <= {1'b0, pow_mag[POWER_W-1:POWER_W-(REM_W-1)]};
				dvd_q  <= {pow_mag[POWER_W-(REM_W-1)-1:0], 10'b0};
				quo_q  <= '0;
				step_q <= '0;
			end
			S_DIV: begin
				rem_q  <= qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
				dvd_q  <= {dvd_q[QUO_W-2:0], 1'b0};
				quo_q  <= {quo_q[QUO_W-2:0], qbit};
				step_q <= step_q + 1'b1;
			end
			S_ACC: begin
				use_q[sel_q] <= 1'b0;
			end
			S_RED: begin
				red_q <= 1'b1;
				if (res_q >= HWH_UNIT) begin
					n_q <= n_q + STEP_W'(1);
				end else if (res_q <= -HWH_UNIT) begin
					n_q <= n_q - STEP_W'(1);
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_mode_q  <= mode_q;
					out_hwh_q   <= hwh_nxt;
					out_pulse_q <= pulse_nxt;
				end
			end
			default: ;
		endcase
	end

	assign result.valid        = out_valid_q;
	assign result.meter_mode   = out_mode_q;
	assign result.energy_total = $signed(out_hwh_q);
	assign result.pulse_count  = out_pulse_q;

	// An accepted item always starts work: the block is busy the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer idle right after an item was accepted");

	// The divider remainder stays below the divisor.
	a_rem_below_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < freq_q))
		else $error("divider remainder not below the frequency");

	// Between items the residual holds less than one hWh.
	a_residual_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((res_q < HWH_UNIT) && (res_q > -HWH_UNIT)))
		else $error("residual left with a whole hWh unit");

	// Pulses are only reported in a running mode.
	a_pulse_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_pulse_q != '0)) |->
		((out_mode_q == MODE_RUN_A) || (out_mode_q == MODE_RUN_B) ||
		 (out_mode_q == MODE_RUN_C) || (out_mode_q == MODE_RUN_THREE)))
		else $error("energy pulses outside a running mode");

	// The sequencer leaves the final step only once the result is registered.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && out_free) |=> out_valid_q)
		else $error("result not registered after the final step");

endmodule
